@@ rtl/nd2_pkg.sv @@
// ----------------------------------------------------------------------------
// nd2_pkg
// shared types and constants for the newton distance block
// ----------------------------------------------------------------------------
package nd2_pkg;

    localparam int unsigned MAX_ITER_DEF    = 64;
    localparam int unsigned COORD_WIDTH_DEF = 24;
    localparam int unsigned TOL_WIDTH       = 32;
    localparam int unsigned DIST_WIDTH      = 25;
    localparam int unsigned SUM_WIDTH       = 64;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd655;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_SQ,
        ST_TEST,
        ST_DIVIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic square;
        logic test;
        logic div_start;
        logic update;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic tol_ok;
        logic div_done;
    } status_t;

endpackage

@@ rtl/nd2_ctrl.sv @@
// ----------------------------------------------------------------------------
// nd2_ctrl
// sequencer for the square, test, divide and update steps
// ----------------------------------------------------------------------------
module nd2_ctrl #(
    parameter int unsigned MAX_ITER = nd2_pkg::MAX_ITER_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output nd2_pkg::cmd_t     cmd,
    input  nd2_pkg::status_t  status,
    output logic              conv_set,
    output logic              conv_val
);
    localparam int unsigned IW = $clog2(MAX_ITER + 1);

    nd2_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   iter_reg, iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nd2_pkg::ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            nd2_pkg::ST_IDLE:   if (s_valid) begin
                state_next = nd2_pkg::ST_SQUARE;
            end
            nd2_pkg::ST_SQUARE: begin
                state_next = nd2_pkg::ST_ROOT_SQ;
                iter_next  = '0;
            end
            // estimate square settles into its register
            nd2_pkg::ST_ROOT_SQ: state_next = nd2_pkg::ST_TEST;
            nd2_pkg::ST_TEST: begin
                if (status.tol_ok || iter_reg == IW'(MAX_ITER))
                    state_next = nd2_pkg::ST_DONE;
                else
                    state_next = nd2_pkg::ST_DIVIDE;
            end
            nd2_pkg::ST_DIVIDE: if (status.div_done) begin
                state_next = nd2_pkg::ST_UPDATE;
            end
            nd2_pkg::ST_UPDATE: begin
                state_next = nd2_pkg::ST_ROOT_SQ;
                iter_next  = iter_reg + 1'b1;
            end
            nd2_pkg::ST_DONE:   if (m_ready) begin
                state_next = nd2_pkg::ST_IDLE;
            end
            default: state_next = nd2_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        cmd           = '0;
        conv_set      = 1'b0;
        conv_val      = 1'b0;
        unique case (state_reg)
            nd2_pkg::ST_IDLE:   begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            nd2_pkg::ST_SQUARE: cmd.square = 1'b1;
            nd2_pkg::ST_ROOT_SQ: ;
            nd2_pkg::ST_TEST: begin
                cmd.test = 1'b1;
                if (status.tol_ok || iter_reg == IW'(MAX_ITER)) begin
                    conv_set = 1'b1;
                    conv_val = status.tol_ok;
                end else begin
                    cmd.div_start = 1'b1;
                end
            end
            nd2_pkg::ST_DIVIDE: ;
            nd2_pkg::ST_UPDATE: cmd.update = 1'b1;
            nd2_pkg::ST_DONE:   m_valid = 1'b1;
            default: ;
        endcase
    end

    a_iter_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        iter_reg <= IW'(MAX_ITER)) else $error("iteration count past cap");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid) else $error("result dropped");
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");
endmodule

@@ rtl/nd2_datapath.sv @@
// ----------------------------------------------------------------------------
// nd2_datapath
// squares, tolerance test, serial 64-bit divider and estimate update
// ----------------------------------------------------------------------------
module nd2_datapath #(
    parameter int unsigned COORD_WIDTH = nd2_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic signed [COORD_WIDTH-1:0]             first_x,
    input  logic signed [COORD_WIDTH-1:0]             first_y,
    input  logic signed [COORD_WIDTH-1:0]             second_x,
    input  logic signed [COORD_WIDTH-1:0]             second_y,
    input  logic [nd2_pkg::TOL_WIDTH-1:0]             tolerance,
    input  nd2_pkg::cmd_t                             cmd,
    output nd2_pkg::status_t                          status,
    input  logic                                      conv_set,
    input  logic                                      conv_val,
    output logic [nd2_pkg::DIST_WIDTH-1:0]            distance,
    output logic                                      converged
);
    localparam int unsigned SW = nd2_pkg::SUM_WIDTH;
    localparam int unsigned DW = COORD_WIDTH + 1;

    logic [DW-1:0]  mx_reg, my_reg;
    logic [SW-1:0]  s_reg, r_reg, sq_reg, q_reg, rem_reg, dvs_reg;
    logic [6:0]     cnt_reg;
    logic           busy_reg, big_reg, conv_reg;
    logic signed [DW-1:0] dx, dy;

    assign dx = DW'(second_x) - DW'(first_x);
    assign dy = DW'(second_y) - DW'(first_y);

    // squares, saturated once a magnitude passes 32 bits
    logic [SW-1:0] sxx, syy;
    logic [SW:0]   ssum;
    always_comb begin
        if (DW > 32 && (mx_reg >> 32) != '0) sxx = '1;
        else sxx = SW'(32'(mx_reg)) * SW'(32'(mx_reg));
        if (DW > 32 && (my_reg >> 32) != '0) syy = '1;
        else syy = SW'(32'(my_reg)) * SW'(32'(my_reg));
        ssum = {1'b0, sxx} + {1'b0, syy};
    end

    // restoring division, one quotient bit per cycle
    logic [SW:0] trial;
    assign trial = {rem_reg, q_reg[SW-1]} - {1'b0, dvs_reg};

    logic [SW-1:0] diff;
    assign diff = (sq_reg >= s_reg) ? sq_reg - s_reg : s_reg - sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (cmd.load) begin
                mx_reg <= dx[DW-1] ? DW'(-dx) : DW'(dx);
                my_reg <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            end
            if (cmd.square) begin
                s_reg <= ssum[SW] ? '1 : ssum[SW-1:0];
                r_reg <= (ssum[SW] ? '1 : ssum[SW-1:0]) >> 9;
            end
            // divider busy flag cleared on a square or update command
            if (cmd.square || cmd.update) busy_reg <= 1'b0;
            if (cmd.div_start) begin
                dvs_reg  <= (r_reg == '0) ? SW'(1) : r_reg;
                r_reg    <= (r_reg == '0) ? SW'(1) : r_reg;
                q_reg    <= s_reg;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg && !status.div_done) begin
                if (!trial[SW]) rem_reg <= trial[SW-1:0];
                else rem_reg <= {rem_reg[SW-2:0], q_reg[SW-1]};
                q_reg   <= {q_reg[SW-2:0], ~trial[SW]};
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.update)
                r_reg <= (r_reg >> 1) + (q_reg >> 1) + SW'(r_reg[0] & q_reg[0]);
            if (cmd.test && conv_set) conv_reg <= conv_val;
        end
    end

    // estimate square computed in a registered step before each test
    logic [SW-1:0] r_sq;
    assign r_sq = SW'(r_reg[31:0]) * SW'(r_reg[31:0]);
    always_ff @(posedge aclk) begin
        sq_reg  <= r_sq;
        big_reg <= r_reg[SW-1:32] != '0;
    end

    assign status.div_done = busy_reg && cnt_reg == 7'(SW);
    assign status.tol_ok   = !big_reg && diff <= SW'(tolerance);
    assign distance  = (r_reg > SW'({nd2_pkg::DIST_WIDTH{1'b1}})) ? '1
                     : r_reg[nd2_pkg::DIST_WIDTH-1:0];
    assign converged = conv_reg;
endmodule

@@ rtl/newton_distance_2d.sv @@
// ----------------------------------------------------------------------------
// newton_distance_2d
// euclidean distance of two Q16.8 points via newton square root
// ----------------------------------------------------------------------------
// One request at a time. The block forms the sum of squared differences, then
// refines the root estimate with Newton steps until its square is within the
// tolerance register or MAX_ITER steps have run. Each step runs a serial divide,
// then the update, estimate-square and test states. The result stays on m_
// lines until taken; the next request is accepted after.
module newton_distance_2d #(
    parameter int unsigned MAX_ITER    = nd2_pkg::MAX_ITER_DEF,
    parameter int unsigned COORD_WIDTH = nd2_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // tolerance register
    input  logic                                  cfg_we,
    input  logic [nd2_pkg::TOL_WIDTH-1:0]         cfg_wdata,
    // input request
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [COORD_WIDTH-1:0]         s_first_x,
    input  logic signed [COORD_WIDTH-1:0]         s_first_y,
    input  logic signed [COORD_WIDTH-1:0]         s_second_x,
    input  logic signed [COORD_WIDTH-1:0]         s_second_y,
    // result request
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nd2_pkg::DIST_WIDTH-1:0]        m_distance,
    output logic                                  m_converged
);
    logic [nd2_pkg::TOL_WIDTH-1:0] tol_reg;
    nd2_pkg::cmd_t    cmd;
    nd2_pkg::status_t status;
    logic             conv_set, conv_val;

    // tolerance; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) tol_reg <= nd2_pkg::TOL_RESET;
        else if (cfg_we) tol_reg <= cfg_wdata;
    end

    nd2_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
        .cmd, .status, .conv_set, .conv_val
    );

    nd2_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .aclk, .aresetn,
        .first_x(s_first_x), .first_y(s_first_y),
        .second_x(s_second_x), .second_y(s_second_y),
        .tolerance(tol_reg), .cmd, .status, .conv_set, .conv_val,
        .distance(m_distance), .converged(m_converged)
    );
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// checks newton_distance_2d against a bit-accurate distance predictor
// ----------------------------------------------------------------------------
// A directed table covers zero distance, the tiny-sum start and coordinate
// extremes. Random requests follow in phases that include tolerance extremes,
// mostly short and medium distances with a few far apart. Both sides idle
// at random. The tolerance is rewritten only when the block is idle.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CW         = nd2_pkg::COORD_WIDTH_DEF;
    localparam int unsigned ITER_CAP   = nd2_pkg::MAX_ITER_DEF;
    localparam int          N_RANDOM   = 150;
    localparam int          N_PHASES   = 5;
    localparam longint      CYCLE_LIMIT = 3_000_000;
    localparam logic [nd2_pkg::DIST_WIDTH-1:0] DIST_SAT = '1;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic                 typed;    // expected value typed in the table
        logic [nd2_pkg::DIST_WIDTH-1:0] want_dist;
        logic                 conv;
    } point_pair_t;

    typedef struct packed {
        logic [nd2_pkg::DIST_WIDTH-1:0] dist_val;
        logic                           conv;
    } distance_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [nd2_pkg::TOL_WIDTH-1:0] cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [CW-1:0]   s_first_x = '0;
    logic signed [CW-1:0]   s_first_y = '0;
    logic signed [CW-1:0]   s_second_x = '0;
    logic signed [CW-1:0]   s_second_y = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [nd2_pkg::DIST_WIDTH-1:0] m_distance;
    logic                   m_converged;

    logic [nd2_pkg::TOL_WIDTH-1:0] tol_reg = nd2_pkg::TOL_RESET;
    distance_t              pending_dist[$];
    int                     mismatches = 0;
    longint                 cycles = 0;

    newton_distance_2d dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_first_x   (s_first_x),
        .s_first_y   (s_first_y),
        .s_second_x  (s_second_x),
        .s_second_y  (s_second_y),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_distance  (m_distance),
        .m_converged (m_converged)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // square of a difference, saturating once the magnitude passes 32 bits
    function automatic logic [63:0] sq_sat(input longint d);
        logic [63:0] m;
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (m > 64'hFFFF_FFFF)
            return '1;
        return m * m;
    endfunction

    function automatic bit root_close(input logic [63:0] r, input logic [63:0] s,
                                      input logic [nd2_pkg::TOL_WIDTH-1:0] tol);
        logic [63:0] sq;
        logic [63:0] diff;
        if (r > 64'hFFFF_FFFF)
            return 1'b0;
        sq = r * r;
        diff = (sq >= s) ? sq - s : s - sq;
        return diff <= 64'(tol);
    endfunction

    // newton square root of the sum of squared differences
    function automatic distance_t predict_distance(input point_pair_t p,
                                                   input logic [nd2_pkg::TOL_WIDTH-1:0] tol);
        longint      dx;
        longint      dy;
        logic [63:0] sx;
        logic [63:0] sy;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] q;
        distance_t   res;
        dx = longint'(p.bx) - longint'(p.ax);
        dy = longint'(p.by) - longint'(p.ay);
        sx = sq_sat(dx);
        sy = sq_sat(dy);
        s  = (sx > ~sy) ? '1 : sx + sy;
        r  = s >> 9;
        res.conv = 1'b0;
        for (int i = 0; i <= ITER_CAP; i++) begin
            if (root_close(r, s, tol)) begin
                res.conv = 1'b1;
                break;
            end
            if (i == ITER_CAP)
                break;
            if (r == 0)
                r = 1;
            q = s / r;
            r = (r >> 1) + (q >> 1) + 64'(r[0] & q[0]);
        end
        res.dist_val = (r > 64'(DIST_SAT)) ? DIST_SAT : r[nd2_pkg::DIST_WIDTH-1:0];
        return res;
    endfunction

    // directed rows: typed expectations only where obvious
    localparam int N_DIRECTED = 14;
    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
    point_pair_t directed_rows [N_DIRECTED] = '{
        '{'0, '0, '0, '0, 1'b1, '0, 1'b1},                  // zero distance
        '{CMAX, CMIN, CMAX, CMIN, 1'b1, '0, 1'b1},          // same point at extremes
        '{'0, '0, 24'sd1, '0, 1'b1, '0, 1'b1},              // tiny sum within tolerance
        '{'0, '0, 24'sd30, '0, 1'b0, '0, 1'b0},             // tiny sum, start from one lsb
        '{'0, '0, 24'sd256, '0, 1'b1, 25'd256, 1'b1},       // exactly one unit
        '{'0, '0, 24'sd768, 24'sd1024, 1'b1, 25'd1280, 1'b1}, // 3-4-5
        '{CMIN, CMIN, CMAX, CMAX, 1'b0, '0, 1'b0},          // largest diagonal
        '{CMAX, CMAX, CMIN, CMIN, 1'b0, '0, 1'b0},
        '{CMIN, '0, CMAX, '0, 1'b0, '0, 1'b0},
        '{'0, CMAX, '0, CMIN, 1'b0, '0, 1'b0},
        '{-24'sd1, -24'sd1, 24'sd1, 24'sd1, 1'b0, '0, 1'b0},
        '{24'sd12345, -24'sd999, -24'sd54321, 24'sd777, 1'b0, '0, 1'b0},
        '{24'h555555, 24'h2AAAAA, 24'h2AAAAA, 24'h555555, 1'b0, '0, 1'b0},
        '{'0, '0, 24'sd7, 24'sd5, 1'b0, '0, 1'b0}
    };

    function automatic logic signed [CW-1:0] rand_coord(input int spread);
        case (spread)
            0: return CW'($signed($urandom_range(0, 2047)) - 1024);
            1: return CW'($signed($urandom_range(0, 262143)) - 131072);
            default: return CW'($urandom);
        endcase
    endfunction

    // valid stays up between back-to-back requests
    task automatic send_request(input point_pair_t p);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_first_x  <= p.ax;
        s_first_y  <= p.ay;
        s_second_x <= p.bx;
        s_second_y <= p.by;
        s_valid    <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (p.typed)
            pending_dist.push_back({p.want_dist, p.conv});
        else
            pending_dist.push_back(predict_distance(p, tol_reg));
        @(negedge aclk);
    endtask

    // block must be idle: all results back plus the tail of the last one
    task automatic write_tolerance(input logic [nd2_pkg::TOL_WIDTH-1:0] val);
        s_valid <= 1'b0;
        while (pending_dist.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_wdata <= val;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        tol_reg    = val;
    endtask

    // result side: a fresh random stall before each result
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, 12);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready && aresetn)) @(posedge aclk);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        distance_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result dist=%0d conv=%0b", m_distance, m_converged);
            end else begin
                want = pending_dist.pop_front();
                if (want.dist_val !== m_distance || want.conv !== m_converged) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: dist exp %0d got %0d, conv exp %0b got %0b",
                                 want.dist_val, m_distance, want.conv, m_converged);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[newton_distance_2d] ERROR");
            $finish;
        end
    end

    initial begin
        point_pair_t p;
        logic [nd2_pkg::TOL_WIDTH-1:0] tol_set [N_PHASES] =
            '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd655, 32'd100000};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i]);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_tolerance(ph == 3 ? nd2_pkg::TOL_RESET : tol_set[ph]);
            for (int i = 0; i < N_RANDOM / N_PHASES; i++) begin
                int pick;
                pick = $urandom_range(0, 9);
                p.ax = rand_coord(pick < 5 ? 0 : (pick < 9 ? 1 : 2));
                p.ay = rand_coord(pick < 5 ? 0 : (pick < 9 ? 1 : 2));
                p.bx = rand_coord(pick < 5 ? 0 : (pick < 9 ? 1 : 2));
                p.by = rand_coord(pick < 5 ? 0 : (pick < 9 ? 1 : 2));
                p.typed = 1'b0;
                p.want_dist = '0;
                p.conv = 1'b0;
                send_request(p);
            end
        end
        write_tolerance($urandom);

        while (pending_dist.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0)
            $display("[newton_distance_2d] OK");
        else
            $display("[newton_distance_2d] ERROR");
        $finish;
    end

endmodule

@@ newton_distance_2d.f @@
rtl/nd2_pkg.sv
rtl/nd2_ctrl.sv
rtl/nd2_datapath.sv
rtl/newton_distance_2d.sv
verif/testbench.sv
